/* hw/rtl/okl_pkg.sv */
// ----------------------------------------------------------------------------
// okl_pkg
// Shared widths, matrix coefficients and types of the Oklab converter.
// ----------------------------------------------------------------------------
package okl_pkg;

  localparam int FRAC_BITS  = 14;
  localparam int CH_W       = 16;
  localparam int COEF_BITS  = 30;
  localparam int LMS_EXTRA  = 8;

  // rgb to lms products and sums
  localparam int COEF_W     = 31;
  localparam int LMS_PROD_W = COEF_W + CH_W;
  localparam int LMS_SUM_W  = LMS_PROD_W + 2;
  localparam int LMS_SHIFT  = COEF_BITS - LMS_EXTRA;
  localparam int LMS_W      = 26;

  // cube root
  localparam int CBRT_FRAC  = 16 + FRAC_BITS / 3;
  localparam int CBRT_SHIFT = 3 * CBRT_FRAC - FRAC_BITS - LMS_EXTRA;
  localparam int REM_W      = 64;
  localparam int CBRT_STEPS = (REM_W - 1) / 3 + 1;
  localparam int ROOT_MAG_W = 22;
  localparam int ROOT_W     = ROOT_MAG_W + 1;
  localparam int SQ_W       = 2 * ROOT_MAG_W;
  localparam int B_W        = SQ_W + 4;

  // lms to lab products and sums
  localparam int LAB_COEF_W = 33;
  localparam int LAB_PROD_W = LAB_COEF_W + ROOT_W;
  localparam int LAB_SUM_W  = LAB_PROD_W + 2;
  localparam int LAB_SHIFT  = COEF_BITS + CBRT_FRAC - FRAC_BITS;
  localparam int LAB_RND_W  = LAB_SUM_W - LAB_SHIFT;

  typedef logic signed [CH_W-1:0]   chan_t;
  typedef logic signed [LMS_W-1:0]  lms_t;
  typedef logic signed [ROOT_W-1:0] root_t;

  localparam logic signed [COEF_W-1:0] RGB2LMS [3][3] = '{
    '{31'sd442619434, 31'sd575882676, 31'sd55239714},
    '{31'sd227529649, 31'sd730895571, 31'sd115316604},
    '{31'sd94814047,  31'sd302493299, 31'sd676434479}
  };

  localparam logic signed [LAB_COEF_W-1:0] LMS2LAB [3][3] = '{
    '{33'sd225973536,  33'sd852140608,   -33'sd4372327},
    '{33'sd2123859712, -33'sd2607681024, 33'sd483821312},
    '{33'sd27814248,   33'sd840494784,   -33'sd868308992}
  };

endpackage

/* hw/rtl/okl_mat_lms.sv */
// ----------------------------------------------------------------------------
// okl_mat_lms
// Two-stage rgb to lms matrix: products, then sum with rounding.
// ----------------------------------------------------------------------------
module okl_mat_lms
  import okl_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  up_valid,
  output logic  up_ready,
  input  chan_t rgb [3],
  output logic  dn_valid,
  input  logic  dn_ready,
  output lms_t  lms [3]
);

  logic                         v1_r, v2_r;
  logic                         adv1, adv2;
  logic signed [LMS_PROD_W-1:0] prod_r   [3][3];
  logic signed [LMS_PROD_W-1:0] prod_nxt [3][3];
  lms_t                         lms_r    [3];
  lms_t                         lms_nxt  [3];
  logic signed [LMS_SUM_W-1:0]  acc      [3];
  logic        [LMS_SUM_W-1:0]  mag      [3];
  logic        [LMS_SUM_W-1:0]  rnd      [3];

  assign adv2     = !v2_r || dn_ready;
  assign adv1     = !v1_r || adv2;
  assign up_ready = adv1;
  assign dn_valid = v2_r;
  assign lms      = lms_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_nxt[i][j] = LMS_PROD_W'(RGB2LMS[i][j]) * LMS_PROD_W'(rgb[j]);
      end
      acc[i] = LMS_SUM_W'(prod_r[i][0]) + LMS_SUM_W'(prod_r[i][1])
             + LMS_SUM_W'(prod_r[i][2]);
      mag[i] = acc[i][LMS_SUM_W-1] ? LMS_SUM_W'(-acc[i]) : LMS_SUM_W'(acc[i]);
      // round half away from zero on the magnitude
      rnd[i] = (mag[i] + (LMS_SUM_W'(1) << (LMS_SHIFT - 1))) >> LMS_SHIFT;
      lms_nxt[i] = acc[i][LMS_SUM_W-1] ? -lms_t'(rnd[i][LMS_W-1:0])
                                       : lms_t'(rnd[i][LMS_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= up_valid;
      if (adv2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && up_valid) prod_r <= prod_nxt;
    if (adv2 && v1_r) lms_r <= lms_nxt;
  end

endmodule

/* hw/rtl/okl_cbrt.sv */
// ----------------------------------------------------------------------------
// okl_cbrt
// Pipelined signed cube root, one root digit per stage, three lanes.
// ----------------------------------------------------------------------------
module okl_cbrt
  import okl_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  up_valid,
  output logic  up_ready,
  input  lms_t  lms [3],
  output logic  dn_valid,
  input  logic  dn_ready,
  output root_t root [3]
);

  localparam int LAST = CBRT_STEPS - 1;

  logic                  v_r   [CBRT_STEPS];
  logic                  adv   [CBRT_STEPS+1];
  logic [REM_W-1:0]      rem_r [CBRT_STEPS][3];
  logic [ROOT_MAG_W-1:0] y_r   [CBRT_STEPS][3];
  logic [SQ_W-1:0]       y2_r  [CBRT_STEPS][3];
  logic                  neg_r [CBRT_STEPS][3];

  always_comb begin
    adv[CBRT_STEPS] = dn_ready;
    for (int k = CBRT_STEPS - 1; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign up_ready = adv[0];
  assign dn_valid = v_r[LAST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < CBRT_STEPS; k++) v_r[k] <= 1'b0;
    end else begin
      v_r[0] <= adv[0] ? up_valid : v_r[0];
      for (int k = 1; k < CBRT_STEPS; k++) begin
        if (adv[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  for (genvar k = 0; k < CBRT_STEPS; k++) begin : g_step
    localparam int S = REM_W - 1 - 3 * k;
    for (genvar c = 0; c < 3; c++) begin : g_lane
      logic [REM_W-1:0]      rem_in, rem_nxt, t;
      logic [ROOT_MAG_W-1:0] y_in, y_sh, y_nxt;
      logic [SQ_W-1:0]       y2_in, y2_sh, y2_nxt;
      logic                  neg_in, take, stage_valid;
      logic [B_W-1:0]        sum, b;

      if (k == 0) begin : g_first
        logic [LMS_W-1:0] mag;
        always_comb begin
          mag         = lms[c][LMS_W-1] ? LMS_W'(-lms[c]) : LMS_W'(lms[c]);
          rem_in      = REM_W'(mag) << CBRT_SHIFT;
          y_in        = '0;
          y2_in       = '0;
          neg_in      = lms[c][LMS_W-1];
          stage_valid = up_valid;
        end
      end else begin : g_rest
        always_comb begin
          rem_in      = rem_r[k-1][c];
          y_in        = y_r[k-1][c];
          y2_in       = y2_r[k-1][c];
          neg_in      = neg_r[k-1][c];
          stage_valid = v_r[k-1];
        end
      end

      always_comb begin
        y_sh  = {y_in[ROOT_MAG_W-2:0], 1'b0};
        y2_sh = {y2_in[SQ_W-3:0], 2'b00};
        sum   = B_W'(y2_sh) + B_W'(y_sh);
        // 3*y*(y+1)+1 from the running square, no multiplier
        b     = (sum << 1) + sum + B_W'(1);
        t     = rem_in >> S;
        take  = (t >= REM_W'(b));
        rem_nxt = take ? rem_in - (REM_W'(b) << S) : rem_in;
        y_nxt   = y_sh + ROOT_MAG_W'(take);
        y2_nxt  = take ? y2_sh + (SQ_W'(y_sh) << 1) + SQ_W'(1) : y2_sh;
      end

      always_ff @(posedge clk) begin
        if (adv[k] && stage_valid) begin
          rem_r[k][c] <= rem_nxt;
          y_r[k][c]   <= y_nxt;
          y2_r[k][c]  <= y2_nxt;
          neg_r[k][c] <= neg_in;
        end
      end

      assign root[c] = neg_r[LAST][c] ? -root_t'(y_r[LAST][c])
                                      : root_t'(y_r[LAST][c]);
    end
  end

  // running square tracks the root
  a_square : assert property (@(posedge clk) disable iff (!rst_n)
    v_r[LAST] |-> (2*SQ_W)'(y2_r[LAST][0]) ==
                  (2*SQ_W)'(y_r[LAST][0]) * (2*SQ_W)'(y_r[LAST][0]))
    else $error("cube root square out of step");

  // floor property: leftover below the next cube step
  a_floor : assert property (@(posedge clk) disable iff (!rst_n)
    v_r[LAST] |-> rem_r[LAST][1] <=
      REM_W'(3) * REM_W'(y2_r[LAST][1]) + REM_W'(3) * REM_W'(y_r[LAST][1]))
    else $error("cube root remainder too large");

  // a finished item holds while the next module is busy
  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    v_r[LAST] && !dn_ready |=> v_r[LAST] && $stable(y_r[LAST][2]))
    else $error("cube root result lost under stall");

endmodule

/* hw/rtl/okl_mat_lab.sv */
// ----------------------------------------------------------------------------
// okl_mat_lab
// Two-stage lms to lab matrix: products, then sum, rounding and saturation.
// ----------------------------------------------------------------------------
module okl_mat_lab
  import okl_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  up_valid,
  output logic  up_ready,
  input  root_t root [3],
  output logic  dn_valid,
  input  logic  dn_ready,
  output chan_t lab [3]
);

  logic                         v1_r, v2_r;
  logic                         adv1, adv2;
  logic signed [LAB_PROD_W-1:0] prod_r   [3][3];
  logic signed [LAB_PROD_W-1:0] prod_nxt [3][3];
  chan_t                        lab_r    [3];
  chan_t                        lab_nxt  [3];
  logic signed [LAB_SUM_W-1:0]  acc      [3];
  logic        [LAB_SUM_W-1:0]  mag      [3];
  logic        [LAB_SUM_W-1:0]  rnd      [3];
  logic        [LAB_RND_W-1:0]  m        [3];

  assign adv2     = !v2_r || dn_ready;
  assign adv1     = !v1_r || adv2;
  assign up_ready = adv1;
  assign dn_valid = v2_r;
  assign lab      = lab_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_nxt[i][j] = LAB_PROD_W'(LMS2LAB[i][j]) * LAB_PROD_W'(root[j]);
      end
      acc[i] = LAB_SUM_W'(prod_r[i][0]) + LAB_SUM_W'(prod_r[i][1])
             + LAB_SUM_W'(prod_r[i][2]);
      mag[i] = acc[i][LAB_SUM_W-1] ? LAB_SUM_W'(-acc[i]) : LAB_SUM_W'(acc[i]);
      rnd[i] = (mag[i] + (LAB_SUM_W'(1) << (LAB_SHIFT - 1))) >> LAB_SHIFT;
      m[i]   = rnd[i][LAB_RND_W-1:0];
      if (acc[i][LAB_SUM_W-1]) begin
        if (m[i] > LAB_RND_W'(32768)) lab_nxt[i] = 16'sh8000;
        else                          lab_nxt[i] = -chan_t'(m[i][CH_W-1:0]);
      end else begin
        if (m[i] > LAB_RND_W'(32767)) lab_nxt[i] = 16'sh7fff;
        else                          lab_nxt[i] = chan_t'(m[i][CH_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= up_valid;
      if (adv2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && up_valid) prod_r <= prod_nxt;
    if (adv2 && v1_r) lab_r <= lab_nxt;
  end

endmodule

/* hw/rtl/linear_rgb_to_oklab.sv */
// pipeline: 2 rgb-to-lms stages, 22 cube root stages at one root digit each,
//   2 lms-to-lab stages
// throughput: one item per cycle when not stalled, every stage holds its own valid bit
// stalls back up stage by stage, empty stages keep filling
// reset: synchronous active-low rst_n clears all valid bits, no other state
// ----------------------------------------------------------------------------
// linear_rgb_to_oklab
// Linear rgb to Oklab in signed Q2.14, fully pipelined.
// ----------------------------------------------------------------------------
module linear_rgb_to_oklab
  import okl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // lin_red, lin_green, lin_blue
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // ok_lightness, ok_green_red, ok_blue_yellow
);

  chan_t rgb  [3];
  chan_t lab  [3];
  lms_t  lms  [3];
  root_t root [3];
  logic  lms_valid, lms_ready, root_valid, root_ready;

  assign rgb[0] = in_tdata[15:0];
  assign rgb[1] = in_tdata[31:16];
  assign rgb[2] = in_tdata[47:32];

  okl_mat_lms u_lms (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .rgb      (rgb),
    .dn_valid (lms_valid),
    .dn_ready (lms_ready),
    .lms      (lms)
  );

  okl_cbrt u_cbrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (lms_valid),
    .up_ready (lms_ready),
    .lms      (lms),
    .dn_valid (root_valid),
    .dn_ready (root_ready),
    .root     (root)
  );

  okl_mat_lab u_lab (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (root_valid),
    .up_ready (root_ready),
    .root     (root),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .lab      (lab)
  );

  assign out_tdata = {lab[2], lab[1], lab[0]};

endmodule

/* bench/linear_rgb_to_oklab_chk.sv */
// ----------------------------------------------------------------------------
// linear_rgb_to_oklab_chk
// Watches both streams of the Oklab converter, computes the expected Lab of
// every accepted pixel and compares it with the pixels that come out.
// ----------------------------------------------------------------------------
module linear_rgb_to_oklab_chk
  import okl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,   // lin_red, lin_green, lin_blue
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,  // ok_lightness, ok_green_red, ok_blue_yellow
  output int          fail_count,
  output int          lab_pending,
  output int          pixels_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    chan_t blue_yellow;
    chan_t green_red;
    chan_t lightness;
  } lab_px_t;

  lab_px_t lab_queue[$];

  function automatic longint round_away(longint v, int s);
    longint unsigned m;
    m = (v < 0) ? longint'(-v) : longint'(v);
    m = (m + (64'd1 << (s - 1))) >> s;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned cube_root_floor(longint unsigned x);
    longint unsigned y;
    longint unsigned b;
    y = 0;
    for (int s = 63; s >= 0; s -= 3) begin
      y = y << 1;
      b = 3 * y * (y + 1) + 1;
      if ((x >> s) >= b) begin
        x = x - (b << s);
        y = y + 1;
      end
    end
    return y;
  endfunction

  function automatic chan_t clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return chan_t'(v);
  endfunction

  function automatic lab_px_t rgb_to_lab(logic [47:0] d);
    longint rgb[3];
    longint root[3];
    longint acc;
    longint lms;
    longint unsigned mag;
    longint lab[3];
    lab_px_t px;
    for (int i = 0; i < 3; i++) rgb[i] = longint'(chan_t'(d[16*i +: 16]));
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += longint'(RGB2LMS[i][j]) * rgb[j];
      lms = round_away(acc, COEF_BITS - LMS_EXTRA);
      mag = (lms < 0) ? longint'(-lms) : longint'(lms);
      mag = cube_root_floor(mag << CBRT_SHIFT);
      root[i] = (lms < 0) ? -longint'(mag) : longint'(mag);
    end
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += longint'(LMS2LAB[i][j]) * root[j];
      lab[i] = round_away(acc, LAB_SHIFT);
    end
    px.lightness   = clamp16(lab[0]);
    px.green_red   = clamp16(lab[1]);
    px.blue_yellow = clamp16(lab[2]);
    return px;
  endfunction

  initial begin
    fail_count  = 0;
    lab_pending = 0;
    pixels_seen = 0;
  end

  always @(posedge clk) begin
    lab_px_t want;
    lab_px_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) lab_queue.push_back(rgb_to_lab(in_tdata));
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        pixels_seen++;
        if (lab_queue.size() == 0) begin
          $error("output item with nothing expected: %h", out_tdata);
          fail_count++;
        end else begin
          want = lab_queue.pop_front();
          if (got.lightness !== want.lightness) begin
            $error("ok_lightness expected %0d got %0d", want.lightness, got.lightness);
            fail_count++;
          end
          if (got.green_red !== want.green_red) begin
            $error("ok_green_red expected %0d got %0d", want.green_red, got.green_red);
            fail_count++;
          end
          if (got.blue_yellow !== want.blue_yellow) begin
            $error("ok_blue_yellow expected %0d got %0d", want.blue_yellow,
                   got.blue_yellow);
            fail_count++;
          end
        end
      end
      lab_pending = lab_queue.size();
    end
  end

endmodule

/* bench/linear_rgb_to_oklab_tb.sv */
// ----------------------------------------------------------------------------
// linear_rgb_to_oklab_tb
// Drives directed and random pixels into the Oklab converter under several
// sender and receiver idling patterns and reports the checker's verdict.
// ----------------------------------------------------------------------------
module linear_rgb_to_oklab_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        took = 1'b0;
  int          fail_count;
  int          lab_pending;
  int          pixels_seen;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          pixels_sent = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  linear_rgb_to_oklab dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata
  );

  linear_rgb_to_oklab_chk chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata,
    .fail_count, .lab_pending, .pixels_seen
  );

  // handshake seen at the last rising edge
  always @(posedge clk) took <= in_tvalid && in_tready;

  always @(negedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // called at a falling edge, returns at a falling edge after acceptance
  task automatic send_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b);
    in_tvalid <= 1'b1;
    in_tdata  <= {b, g, r};
    do @(negedge clk); while (!took);
    pixels_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
  endtask

  task automatic send_random(int n);
    logic [15:0] c[3];
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < 3; i++) begin
        case ($urandom_range(3))
          0: c[i] = 16'($urandom);                 // any code, negatives too
          1: c[i] = 16'($urandom_range(16384));    // ordinary color range 0..1.0
          2: c[i] = 16'($urandom_range(255));      // near black
          default: c[i] = 16'($urandom_range(32767, 24576));  // bright, may saturate
        endcase
      end
      send_pixel(c[0], c[1], c[2]);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed corners
    send_pixel(16'h0000, 16'h0000, 16'h0000);
    send_pixel(16'h7fff, 16'h7fff, 16'h7fff);
    send_pixel(16'h8000, 16'h8000, 16'h8000);
    send_pixel(16'h4000, 16'h4000, 16'h4000);
    send_pixel(16'h7fff, 16'h0000, 16'h0000);
    send_pixel(16'h0000, 16'h7fff, 16'h0000);
    send_pixel(16'h0000, 16'h0000, 16'h7fff);
    send_pixel(16'h8000, 16'h0000, 16'h0000);
    send_pixel(16'h0000, 16'h8000, 16'h0000);
    send_pixel(16'h0000, 16'h0000, 16'h8000);
    send_pixel(16'h7fff, 16'h8000, 16'h7fff);
    send_pixel(16'h8000, 16'h7fff, 16'h8000);
    send_pixel(16'h0001, 16'h0001, 16'h0001);
    send_pixel(16'hffff, 16'hffff, 16'hffff);
    send_pixel(16'h4000, 16'h0000, 16'h0000);
    send_pixel(16'h0000, 16'h4000, 16'h0000);
    send_pixel(16'h0000, 16'h0000, 16'h4000);
    send_pixel(16'h0000, 16'h7fff, 16'h8000);
    send_pixel(16'haaaa, 16'h5555, 16'haaaa);
    send_pixel(16'h5555, 16'haaaa, 16'h5555);

    send_random(200);

    // let the pipeline drain fully before going on
    in_tvalid <= 1'b0;
    while (lab_pending != 0) @(negedge clk);

    send_idle_pct = 48;
    send_random(210);
    send_idle_pct = 0;
    recv_stall_pct = 48;
    send_random(210);
    send_idle_pct = 36;
    recv_stall_pct = 36;
    send_random(210);
    in_tvalid <= 1'b0;
    recv_stall_pct = 0;

    while (lab_pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("sent %0d pixels (corners, random full-range and in-gamut colors),",
             pixels_sent);
    $display("checked %0d results under sender idling and receiver stalls", pixels_seen);
    if (fail_count == 0 && lab_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
